[src/keyed_image_slot_cache_top_defines.svh]
// ----------------------------------------------------------------------------
// keyed image slot cache assertion macros
// Assertion helpers shared by the cache RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef KEYED_IMAGE_SLOT_CACHE_TOP_DEFINES_SVH
`define KEYED_IMAGE_SLOT_CACHE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define KISC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define KISC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KISC_ASSERT_IMP(lbl, ante, cons, msg)
`define KISC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[src/kisc_pkg.sv]
// ----------------------------------------------------------------------------
// kisc_pkg
// Constants, opcodes and shared types of the keyed image slot cache.
// ----------------------------------------------------------------------------
package kisc_pkg;

   localparam int DEF_SLOT_COUNT = 8;
   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;

   localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
   localparam logic [7:0]  UNBOUND       = 8'hFF;

   localparam logic [3:0] OP_BEGIN        = 4'd0;
   localparam logic [3:0] OP_BEGIN_KEYED  = 4'd1;
   localparam logic [3:0] OP_WRITE_PIXEL  = 4'd2;
   localparam logic [3:0] OP_COMMIT       = 4'd3;
   localparam logic [3:0] OP_COMMIT_KEYED = 4'd4;
   localparam logic [3:0] OP_CANCEL       = 4'd5;
   localparam logic [3:0] OP_TIMEOUT      = 4'd6;
   localparam logic [3:0] OP_BIND         = 4'd7;
   localparam logic [3:0] OP_FIND_KEY     = 4'd8;
   localparam logic [3:0] OP_FIND_ITEM    = 4'd9;
   localparam logic [3:0] OP_INFO         = 4'd10;
   localparam logic [3:0] OP_READ_PIXEL   = 4'd11;
   localparam logic [3:0] OP_CLEAR_BIND   = 4'd12;
   localparam logic [3:0] OP_INVALIDATE   = 4'd13;
   localparam logic [3:0] OP_TAKE_EVICTED = 4'd14;

   typedef struct packed {
      logic wr;
      logic rd;
   } pix_cmd_type;

endpackage

[src/kisc_pix_mem.sv]
// ----------------------------------------------------------------------------
// kisc_pix_mem
// Pixel memory: one buffer per slot plus one spare upload buffer.
// ----------------------------------------------------------------------------
module kisc_pix_mem import kisc_pkg::*; #(
   parameter int DEPTH = 2,
   parameter int AW    = 1
) (
   input  logic        clock,
   input  pix_cmd_type cmd,
   input  logic [AW-1:0] addr,
   input  logic [15:0] wdata,
   output logic [15:0] rdata
);

   logic [15:0] mem [DEPTH];
   logic [15:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[addr] <= wdata;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/keyed_image_slot_cache_top.sv]
// ----------------------------------------------------------------------------
// keyed_image_slot_cache_top
// Keyed image slot cache with staged uploads and LRU slot replacement.
// ----------------------------------------------------------------------------
// Commands enter on start while busy is low; each gives exactly one response
// beat on rsp_valid, held for one cycle, which the receiver cannot stall.
// Most commands answer straight from idle, so busy stays low and a new command
// can follow at once. A pixel read passes through the pixel state (registered read of the pixel memory).
// Begin keyed, bind, find key and find item walk the slot table one entry
// per cycle in the scan state and answer from the finish state. Commit
// copies nothing: uploads are staged in a spare buffer that is swapped into
// the slot on commit. There is no clearing pass after reset.
`include "keyed_image_slot_cache_top_defines.svh"
module keyed_image_slot_cache_top import kisc_pkg::*; #(
   parameter int SLOT_COUNT = DEF_SLOT_COUNT,
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [3:0]        req_opcode,
   input  logic [31:0]       req_now_ms,
   input  logic [3:0]        req_slot_number,
   input  logic [7:0]        req_item_index,
   input  logic [31:0]       req_image_key,
   input  logic [9:0]        req_image_width,
   input  logic [9:0]        req_image_height,
   input  logic [15:0]       req_pixel_offset,
   input  logic [15:0]       req_pixel_value,
   output logic              rsp_valid,
   output logic              rsp_ok,
   output logic signed [4:0] rsp_found_slot,
   output logic [31:0]       rsp_key_out,
   output logic [7:0]        rsp_item_out,
   output logic [8:0]        rsp_width_out,
   output logic [8:0]        rsp_height_out,
   output logic              rsp_valid_out,
   output logic [15:0]       rsp_pixel_out,
   output logic              rsp_write_active,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata
);

   localparam int SLOT_PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIX_AW = (SLOT_PIXELS > 1) ? $clog2(SLOT_PIXELS) : 1;
   localparam int SW     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int BW     = $clog2(SLOT_COUNT + 1);
   localparam int MEM_AW = BW + PIX_AW;
   localparam int MEM_DEPTH = (SLOT_COUNT + 1) * (2 ** PIX_AW);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;
   localparam logic [1:0] ST_PIX  = 2'd3;

   // slot table
   logic [31:0] ent_key_ff [SLOT_COUNT];
   logic [31:0] ent_key_in [SLOT_COUNT];
   logic [7:0]  ent_item_ff [SLOT_COUNT];
   logic [7:0]  ent_item_in [SLOT_COUNT];
   logic [8:0]  ent_w_ff [SLOT_COUNT];
   logic [8:0]  ent_w_in [SLOT_COUNT];
   logic [8:0]  ent_h_ff [SLOT_COUNT];
   logic [8:0]  ent_h_in [SLOT_COUNT];
   logic [31:0] ent_lu_ff [SLOT_COUNT];
   logic [31:0] ent_lu_in [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] ent_valid_ff, ent_valid_in;
   logic [BW-1:0] map_ff [SLOT_COUNT];
   logic [BW-1:0] map_in [SLOT_COUNT];
   logic [BW-1:0] free_ff, free_in;

   // upload state
   logic [31:0] timeout_ff, timeout_in;
   logic [8:0]  up_w_ff, up_w_in, up_h_ff, up_h_in;
   logic [16:0] up_cnt_ff, up_cnt_in;
   logic [7:0]  up_item_ff, up_item_in;
   logic [SW-1:0] up_slot_ff, up_slot_in;
   logic [31:0] up_key_ff, up_key_in;
   logic        up_active_ff, up_active_in;
   logic [31:0] evict_ff, evict_in;
   logic [31:0] last_act_ff, last_act_in;

   // sequencer
   logic [1:0]    state_ff, state_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic          hit_found_ff, hit_found_in, inv_found_ff, inv_found_in;
   logic          itm_found_ff, itm_found_in;
   logic [SW-1:0] hit_idx_ff, hit_idx_in, inv_idx_ff, inv_idx_in;
   logic [SW-1:0] itm_idx_ff, itm_idx_in, lru_idx_ff, lru_idx_in;
   logic [31:0]   lru_val_ff, lru_val_in;
   logic [3:0]    q_op_ff, q_op_in;
   logic [31:0]   q_now_ff, q_now_in, q_key_ff, q_key_in;
   logic [7:0]    q_item_ff, q_item_in;
   logic [8:0]    q_w_ff, q_w_in, q_h_ff, q_h_in;
   logic          pix_ok_ff, pix_ok_in;

   // response
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic signed [4:0] rsp_found_ff, rsp_found_in;
   logic [31:0]       rsp_key_ff, rsp_key_in;
   logic [7:0]        rsp_item_ff, rsp_item_in;
   logic [8:0]        rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;
   logic              rsp_vo_ff, rsp_vo_in;
   logic [15:0]       rsp_pix_ff, rsp_pix_in;
   logic              rsp_wa_ff, rsp_wa_in;

   // pixel memory port
   pix_cmd_type       pm_cmd;
   logic [MEM_AW-1:0] pm_addr;
   logic [15:0]       pm_rdata;

   logic          accept;
   logic          is_commit;
   logic [SW-1:0] req_slot;
   logic [SW-1:0] meta_idx;
   logic          slot_in_range;
   logic [31:0]   m_key, m_lu;
   logic [7:0]    m_item;
   logic [8:0]    m_w, m_h;
   logic          m_valid;
   logic [BW-1:0] m_map;
   logic          expired, act_x, size_ok, text_only;
   logic [17:0]   expected, m_area;
   logic          in_order, overflow, can_commit, pix_in_range;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign is_commit = (req_opcode == OP_COMMIT) || (req_opcode == OP_COMMIT_KEYED);
   assign req_slot  = req_slot_number[SW-1:0];
   assign slot_in_range = ({1'b0, req_slot_number} < 5'(SLOT_COUNT));

   // shared read port into the slot table (bind's unbind pass reads all item fields directly)
   assign meta_idx = (state_ff == ST_SCAN) ? scan_ff : (is_commit ? up_slot_ff : req_slot);
   assign m_key   = ent_key_ff[meta_idx];
   assign m_item  = ent_item_ff[meta_idx];
   assign m_w     = ent_w_ff[meta_idx];
   assign m_h     = ent_h_ff[meta_idx];
   assign m_lu    = ent_lu_ff[meta_idx];
   assign m_valid = ent_valid_ff[meta_idx];
   assign m_map   = map_ff[meta_idx];

   assign expired   = up_active_ff && ((req_now_ms - last_act_ff) >= timeout_ff);
   assign act_x     = up_active_ff && !expired;
   assign text_only = (req_image_width == 10'd0) && (req_image_height == 10'd0);
   assign size_ok   = (req_image_width != 10'd0) && (req_image_height != 10'd0) &&
                      (req_image_width <= 10'(MAX_WIDTH)) &&
                      (req_image_height <= 10'(MAX_HEIGHT));
   assign expected  = 18'(up_w_ff) * 18'(up_h_ff);
   assign m_area    = 18'(m_w) * 18'(m_h);
   assign in_order  = act_x && ({1'b0, req_pixel_offset} == up_cnt_ff);
   assign overflow  = ((18'(req_pixel_offset) + 18'd1) > expected) ||
                      ({1'b0, req_pixel_offset} >= 17'(SLOT_PIXELS));
   assign can_commit = act_x && ({1'b0, up_cnt_ff} == expected);
   assign pix_in_range = (18'(req_pixel_offset) < m_area) &&
                         ({1'b0, req_pixel_offset} < 17'(SLOT_PIXELS));

   always_comb begin
      logic [SW-1:0] pick;
      ent_key_in   = ent_key_ff;
      ent_item_in  = ent_item_ff;
      ent_w_in     = ent_w_ff;
      ent_h_in     = ent_h_ff;
      ent_lu_in    = ent_lu_ff;
      ent_valid_in = ent_valid_ff;
      map_in       = map_ff;
      free_in      = free_ff;
      timeout_in   = csr_we ? csr_wdata : timeout_ff;
      up_w_in      = up_w_ff;
      up_h_in      = up_h_ff;
      up_cnt_in    = up_cnt_ff;
      up_item_in   = up_item_ff;
      up_slot_in   = up_slot_ff;
      up_key_in    = up_key_ff;
      up_active_in = up_active_ff;
      evict_in     = evict_ff;
      last_act_in  = last_act_ff;
      state_in     = state_ff;
      scan_in      = scan_ff;
      hit_found_in = hit_found_ff;
      hit_idx_in   = hit_idx_ff;
      inv_found_in = inv_found_ff;
      inv_idx_in   = inv_idx_ff;
      itm_found_in = itm_found_ff;
      itm_idx_in   = itm_idx_ff;
      lru_idx_in   = lru_idx_ff;
      lru_val_in   = lru_val_ff;
      q_op_in      = q_op_ff;
      q_now_in     = q_now_ff;
      q_key_in     = q_key_ff;
      q_item_in    = q_item_ff;
      q_w_in       = q_w_ff;
      q_h_in       = q_h_ff;
      pix_ok_in    = pix_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_found_in = -5'sd1;
      rsp_key_in   = '0;
      rsp_item_in  = '0;
      rsp_w_in     = '0;
      rsp_h_in     = '0;
      rsp_vo_in    = 1'b0;
      rsp_pix_in   = '0;
      pm_cmd       = '0;
      pm_addr      = {free_ff, req_pixel_offset[PIX_AW-1:0]};
      pick         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               q_op_in   = req_opcode;
               q_now_in  = req_now_ms;
               q_key_in  = req_image_key;
               q_item_in = req_item_index;
               q_w_in    = req_image_width[8:0];
               q_h_in    = req_image_height[8:0];
               scan_in      = '0;
               hit_found_in = 1'b0;
               inv_found_in = 1'b0;
               itm_found_in = 1'b0;
               unique case (req_opcode)
                  OP_BEGIN: begin
                     if (!slot_in_range || (!text_only && !size_ok)) begin
                        up_active_in = 1'b0;
                     end else begin
                        up_w_in      = req_image_width[8:0];
                        up_h_in      = req_image_height[8:0];
                        up_cnt_in    = '0;
                        up_item_in   = req_item_index;
                        up_key_in    = '0;
                        up_slot_in   = req_slot;
                        up_active_in = !text_only;
                        last_act_in  = req_now_ms;
                        rsp_ok_in    = 1'b1;
                     end
                  end
                  OP_BEGIN_KEYED: begin
                     if (req_image_key != 32'd0 && size_ok) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  OP_WRITE_PIXEL: begin
                     if (expired) begin
                        up_active_in = 1'b0;
                     end
                     if (in_order) begin
                        if (overflow) begin
                           up_active_in = 1'b0;
                        end else begin
                           pm_cmd.wr   = 1'b1;
                           up_cnt_in   = up_cnt_ff + 17'd1;
                           last_act_in = req_now_ms;
                           rsp_ok_in   = 1'b1;
                        end
                     end
                  end
                  OP_COMMIT, OP_COMMIT_KEYED: begin
                     if (req_opcode == OP_COMMIT || up_key_ff != 32'd0) begin
                        if (expired) begin
                           up_active_in = 1'b0;
                        end
                        if (can_commit) begin
                           up_active_in = 1'b0;
                           if (up_key_ff != 32'd0 && m_valid && m_key != up_key_ff) begin
                              evict_in = m_key;
                           end
                           // staged buffer becomes the slot image, old one is spare
                           map_in[up_slot_ff]       = free_ff;
                           free_in                  = m_map;
                           ent_key_in[up_slot_ff]   = up_key_ff;
                           ent_item_in[up_slot_ff]  = up_item_ff;
                           ent_w_in[up_slot_ff]     = up_w_ff;
                           ent_h_in[up_slot_ff]     = up_h_ff;
                           ent_valid_in[up_slot_ff] = 1'b1;
                           ent_lu_in[up_slot_ff]    = req_now_ms;
                           rsp_ok_in = 1'b1;
                        end
                     end
                  end
                  OP_CANCEL: begin
                     up_active_in = 1'b0;
                     rsp_ok_in    = 1'b1;
                  end
                  OP_TIMEOUT: begin
                     if (expired) begin
                        up_active_in = 1'b0;
                     end
                     rsp_ok_in = 1'b1;
                  end
                  OP_BIND, OP_FIND_KEY: begin
                     if (req_image_key != 32'd0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = ST_SCAN;
                     end
                  end
                  OP_FIND_ITEM: begin
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SCAN;
                  end
                  OP_INFO: begin
                     if (slot_in_range && m_valid) begin
                        rsp_ok_in   = 1'b1;
                        rsp_key_in  = m_key;
                        rsp_item_in = m_item;
                        rsp_w_in    = m_w;
                        rsp_h_in    = m_h;
                        rsp_vo_in   = 1'b1;
                     end
                  end
                  OP_READ_PIXEL: begin
                     if (slot_in_range && m_valid) begin
                        ent_lu_in[req_slot] = req_now_ms;
                        pm_cmd.rd    = 1'b1;
                        pm_addr      = {m_map, req_pixel_offset[PIX_AW-1:0]};
                        pix_ok_in    = pix_in_range;
                        rsp_valid_in = 1'b0;
                        state_in     = ST_PIX;
                     end
                  end
                  OP_CLEAR_BIND: begin
                     up_active_in = 1'b0;
                     for (int t = 0; t < SLOT_COUNT; t++) begin
                        ent_item_in[t] = UNBOUND;
                     end
                     rsp_ok_in = 1'b1;
                  end
                  OP_INVALIDATE: begin
                     up_active_in = 1'b0;
                     ent_valid_in = '0;
                     rsp_ok_in    = 1'b1;
                  end
                  OP_TAKE_EVICTED: begin
                     rsp_key_in = evict_ff;
                     evict_in   = '0;
                     rsp_ok_in  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!hit_found_ff && m_valid && m_key == q_key_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = scan_ff;
            end
            if (!inv_found_ff && !m_valid) begin
               inv_found_in = 1'b1;
               inv_idx_in   = scan_ff;
            end
            if (!itm_found_ff && m_valid && m_item == q_item_ff) begin
               itm_found_in = 1'b1;
               itm_idx_in   = scan_ff;
            end
            // strict compare keeps the lowest slot on a tie
            if (scan_ff == '0 || m_lu < lru_val_ff) begin
               lru_idx_in = scan_ff;
               lru_val_in = m_lu;
            end
            if (scan_ff == SW'(SLOT_COUNT - 1)) begin
               state_in = ST_FIN;
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end
         ST_FIN: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            priority case (q_op_ff)
               OP_BEGIN_KEYED: begin
                  if (hit_found_ff) begin
                     pick = hit_idx_ff;
                  end else if (inv_found_ff) begin
                     pick = inv_idx_ff;
                  end else begin
                     pick = lru_idx_ff;
                  end
                  evict_in     = '0;
                  up_w_in      = q_w_ff;
                  up_h_in      = q_h_ff;
                  up_cnt_in    = '0;
                  up_item_in   = UNBOUND;
                  up_key_in    = q_key_ff;
                  up_slot_in   = pick;
                  up_active_in = 1'b1;
                  last_act_in  = q_now_ff;
                  rsp_ok_in    = 1'b1;
               end
               OP_BIND: begin
                  if (hit_found_ff) begin
                     for (int t = 0; t < SLOT_COUNT; t++) begin
                        if (ent_item_ff[t] == q_item_ff) begin
                           ent_item_in[t] = UNBOUND;
                        end
                     end
                     ent_item_in[hit_idx_ff] = q_item_ff;
                     ent_lu_in[hit_idx_ff]   = q_now_ff;
                     rsp_ok_in = 1'b1;
                  end
               end
               OP_FIND_KEY: begin
                  if (hit_found_ff) begin
                     rsp_found_in = 5'(hit_idx_ff);
                     rsp_ok_in    = 1'b1;
                  end
               end
               default: begin
                  if (itm_found_ff) begin
                     rsp_found_in = 5'(itm_idx_ff);
                     rsp_ok_in    = 1'b1;
                  end
               end
            endcase
         end
         ST_PIX: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = pix_ok_ff;
            rsp_pix_in   = pix_ok_ff ? pm_rdata : 16'd0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_wa_in = up_active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= '0;
         for (int t = 0; t < SLOT_COUNT; t++) begin
            map_ff[t] <= BW'(t);
         end
         free_ff      <= BW'(SLOT_COUNT);
         timeout_ff   <= TIMEOUT_RESET;
         up_slot_ff   <= '0;
         up_active_ff <= 1'b0;
         evict_ff     <= '0;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         ent_valid_ff <= ent_valid_in;
         map_ff       <= map_in;
         free_ff      <= free_in;
         timeout_ff   <= timeout_in;
         up_slot_ff   <= up_slot_in;
         up_active_ff <= up_active_in;
         evict_ff     <= evict_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_key_ff   <= ent_key_in;
      ent_item_ff  <= ent_item_in;
      ent_w_ff     <= ent_w_in;
      ent_h_ff     <= ent_h_in;
      ent_lu_ff    <= ent_lu_in;
      up_w_ff      <= up_w_in;
      up_h_ff      <= up_h_in;
      up_cnt_ff    <= up_cnt_in;
      up_item_ff   <= up_item_in;
      up_key_ff    <= up_key_in;
      last_act_ff  <= last_act_in;
      scan_ff      <= scan_in;
      hit_found_ff <= hit_found_in;
      hit_idx_ff   <= hit_idx_in;
      inv_found_ff <= inv_found_in;
      inv_idx_ff   <= inv_idx_in;
      itm_found_ff <= itm_found_in;
      itm_idx_ff   <= itm_idx_in;
      lru_idx_ff   <= lru_idx_in;
      lru_val_ff   <= lru_val_in;
      q_op_ff      <= q_op_in;
      q_now_ff     <= q_now_in;
      q_key_ff     <= q_key_in;
      q_item_ff    <= q_item_in;
      q_w_ff       <= q_w_in;
      q_h_ff       <= q_h_in;
      pix_ok_ff    <= pix_ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_item_ff  <= rsp_item_in;
      rsp_w_ff     <= rsp_w_in;
      rsp_h_ff     <= rsp_h_in;
      rsp_vo_ff    <= rsp_vo_in;
      rsp_pix_ff   <= rsp_pix_in;
      rsp_wa_ff    <= rsp_wa_in;
   end

   kisc_pix_mem #(
      .DEPTH (MEM_DEPTH),
      .AW    (MEM_AW)
   ) u_pix_mem (
      .clock (clock),
      .cmd   (pm_cmd),
      .addr  (pm_addr),
      .wdata (req_pixel_value),
      .rdata (pm_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_found_slot   = rsp_found_ff;
   assign rsp_key_out      = rsp_key_ff;
   assign rsp_item_out     = rsp_item_ff;
   assign rsp_width_out    = rsp_w_ff;
   assign rsp_height_out   = rsp_h_ff;
   assign rsp_valid_out    = rsp_vo_ff;
   assign rsp_pixel_out    = rsp_pix_ff;
   assign rsp_write_active = rsp_wa_ff;

   `KISC_ASSERT_IMP(a_rsp_in_idle, rsp_valid_ff, state_ff == ST_IDLE, "response outside idle")
   `KISC_ASSERT_NXT(a_pix_done, state_ff == ST_PIX, rsp_valid_ff, "pixel read gave no beat")
   `KISC_ASSERT_NXT(a_fin_done, state_ff == ST_FIN, rsp_valid_ff, "slot walk gave no beat")
   `KISC_ASSERT_IMP(a_spare_free, 1'b1, free_ff != map_ff[up_slot_ff], "spare buffer mapped")
   `KISC_ASSERT_IMP(a_wa_match, rsp_valid_ff, rsp_wa_ff == up_active_ff, "write_active stale")

endmodule
